// ----- rtl/core/detc_pkg.sv -----
// Shared types, formats and codes for the drive engine throttle controller.
// No dependencies; every other file of the block imports this package.
package detc_pkg;

    // Field formats
    localparam int SPEED_WIDTH    = 16;
    localparam int POWER_WIDTH    = 16;
    localparam int SPD_FRAC       = SPEED_WIDTH - 4;
    localparam int PWR_FRAC       = POWER_WIDTH - 2;
    localparam int GAIN_WIDTH     = 6;
    localparam int DRIVE_WIDTH    = 15;
    localparam int DRIVE_FRAC     = 14;
    localparam int CFG_DATA_WIDTH = 15;
    localparam int TIME_WIDTH     = 16;
    localparam int TIME_FRAC      = 12;
    localparam int LAMP_WIDTH     = 6;

    localparam int PMAG_WIDTH = PWR_FRAC + 1;
    localparam int MAX_FRAC   = (SPD_FRAC > PWR_FRAC) ? SPD_FRAC : PWR_FRAC;

    // Speed error to power: shift product by the format difference
    localparam int ERR_SHL   = (PWR_FRAC >= SPD_FRAC) ? PWR_FRAC - SPD_FRAC : 0;
    localparam int ERR_SHR   = (PWR_FRAC >= SPD_FRAC) ? 0 : SPD_FRAC - PWR_FRAC;
    localparam int ESC_WIDTH = MAX_FRAC + GAIN_WIDTH;

    // Q1.14 register values to power format
    localparam int Q14_SHL   = (PWR_FRAC >= DRIVE_FRAC) ? PWR_FRAC - DRIVE_FRAC : 0;
    localparam int Q14_SHR   = (PWR_FRAC >= DRIVE_FRAC) ? 0 : DRIVE_FRAC - PWR_FRAC;
    localparam int Q14_WIDTH = (PMAG_WIDTH > DRIVE_WIDTH) ? PMAG_WIDTH : DRIVE_WIDTH;

    // Divide by seven through a reciprocal, exact for numerators up to 2*one
    localparam int DIV7_SHIFT     = PWR_FRAC + 4;
    localparam int DIV7_NUM_WIDTH = PWR_FRAC + 2;
    localparam int DIV7_MUL_WIDTH = DIV7_SHIFT - 2;
    localparam int DIV7_PRD_WIDTH = DIV7_NUM_WIDTH + DIV7_MUL_WIDTH;

    // Ramp step product
    localparam int MPROD_WIDTH = PMAG_WIDTH + TIME_WIDTH;
    localparam int MAG_WIDTH   = MPROD_WIDTH - TIME_FRAC;

    typedef logic signed [SPEED_WIDTH-1:0] speed_t;
    typedef logic signed [SPEED_WIDTH:0]   act_t;
    typedef logic signed [SPEED_WIDTH+1:0] err_t;
    typedef logic        [SPEED_WIDTH:0]   aerr_t;
    typedef logic        [PWR_FRAC:0]      pmag_t;
    typedef logic signed [POWER_WIDTH-1:0] power_t;
    typedef logic        [TIME_WIDTH-1:0]  dtime_t;
    typedef logic        [GAIN_WIDTH-1:0]  gain_t;
    typedef logic        [DRIVE_WIDTH-1:0] drive_t;
    typedef logic        [CFG_DATA_WIDTH-1:0] cfg_data_t;
    typedef logic        [LAMP_WIDTH-1:0]  lamp_t;
    typedef logic        [ESC_WIDTH-1:0]   esc_t;
    typedef logic        [Q14_WIDTH-1:0]   q14_t;
    typedef logic        [DIV7_NUM_WIDTH-1:0] div7_num_t;
    typedef logic        [DIV7_MUL_WIDTH-1:0] div7_mul_t;
    typedef logic        [DIV7_PRD_WIDTH-1:0] div7_prd_t;
    typedef logic        [MPROD_WIDTH-1:0] mprod_t;
    typedef logic        [MAG_WIDTH-1:0]   mag_t;

    localparam pmag_t     PWR_ONE  = pmag_t'(longint'(1) << PWR_FRAC);
    localparam aerr_t     SPD_ONE  = aerr_t'(longint'(1) << SPD_FRAC);
    localparam aerr_t     TOL_GOAL = aerr_t'(((longint'(1) << SPD_FRAC) + 50) / 100);
    localparam aerr_t     TOL_DEAD = aerr_t'(((longint'(1) << SPD_FRAC) + 100) / 200);
    localparam div7_mul_t DIV7_MUL = div7_mul_t'(((longint'(1) << DIV7_SHIFT) + 6) / 7);

    // Configuration registers
    typedef enum logic [1:0] {
        CFG_ERROR_GAIN = 2'd0,
        CFG_MIN_DRIVE  = 2'd1,
        CFG_HOLD_DRIVE = 2'd2,
        CFG_RAMP_RATE  = 2'd3
    } cfg_index_t;

    typedef struct packed {
        gain_t  error_gain;
        drive_t min_drive;
        drive_t hold_drive;
        drive_t ramp_rate;
    } cfg_t;

    localparam gain_t  ERROR_GAIN_RESET = gain_t'(10);
    localparam drive_t MIN_DRIVE_RESET  = drive_t'(4915);
    localparam drive_t HOLD_DRIVE_RESET = drive_t'(4096);
    localparam drive_t RAMP_RATE_RESET  = drive_t'(819);

    // Cab and button codes
    localparam logic [1:0] CAB_FRONT = 2'd1;
    localparam logic [1:0] CAB_REAR  = 2'd2;
    localparam int BTN_NEUT = 0;
    localparam int BTN_FWD  = 1;
    localparam int BTN_REV  = 2;

    typedef enum logic [1:0] {
        DIR_NEUT = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_START = 2'd1,
        MODE_ON    = 2'd2,
        MODE_STOP  = 2'd3
    } mode_t;

    localparam lamp_t LAMP_NEUT = 6'h03;
    localparam lamp_t LAMP_FWD  = 6'h24;
    localparam lamp_t LAMP_REV  = 6'h18;

    // Sequencer
    typedef enum logic [2:0] {
        SEQ_IDLE   = 3'd0,
        SEQ_EVAL   = 3'd1,
        SEQ_SCALE  = 3'd2,
        SEQ_PICK   = 3'd3,
        SEQ_RAMP   = 3'd4,
        SEQ_COMMIT = 3'd5
    } seq_state_t;

    typedef struct packed {
        logic load;
        logic eval;
        logic scale;
        logic pick;
        logic ramp;
        logic commit;
    } dp_cmd_t;

endpackage

// ----- rtl/core/drive_engine_throttle_controller_unit.sv -----
// Top level of the drive engine throttle controller.
// Depends on detc_pkg, detc_cfg, detc_ctrl and detc_dp.
//
//   channel   handshake               payload
//   -------   ---------------------   ------------------------------------------
//   input     in_valid / in_stall     cab, buttons, sound busy, speeds, goals, time
//   output    out_valid / out_stall   power, mode, direction, lamps, sound pulses
//   config    cfg_we (no wait)        cfg_index, cfg_data
//
// From acceptance to the next acceptance an item passes through one load, then
// the sequencer steps error/target, divide-by-seven multiply, target pick, slew
// multiply and commit. Commit waits while an earlier result item is held by
// out_stall; a new item is taken as soon as the commit is done.
// Reset (rst_n low, asynchronous) sets direction neutral, engine off, power
// zero and the configuration registers to their defaults; no clearing pass.
module drive_engine_throttle_controller_unit
    import detc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    // Configuration write port
    input  logic       cfg_we,
    input  cfg_index_t cfg_index,
    input  cfg_data_t  cfg_data,

    // Input item
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] active_cab,
    input  logic [2:0] buttons_front,
    input  logic [2:0] buttons_rear,
    input  logic       start_sound_busy,
    input  logic       stop_sound_busy,
    input  speed_t     speed_front,
    input  speed_t     goal_front,
    input  speed_t     speed_rear,
    input  speed_t     goal_rear,
    input  dtime_t     step_time,
    input  logic       fast_time,

    // Result item
    output logic       out_valid,
    input  logic       out_stall,
    output power_t     drive_power,
    output logic [1:0] engine_mode,
    output logic [1:0] travel_direction,
    output lamp_t      lamp_pattern,
    output logic       start_sound_pulse,
    output logic       stop_sound_pulse,
    output logic       run_sound_pulse
);

    cfg_t    cfg;
    dp_cmd_t cmd;

    // Hold the four tuning registers
    detc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequence each item and track the result register
    detc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // Latch direction, advance the engine mode, slew power
    detc_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .cfg               (cfg),
        .active_cab        (active_cab),
        .buttons_front     (buttons_front),
        .buttons_rear      (buttons_rear),
        .start_sound_busy  (start_sound_busy),
        .stop_sound_busy   (stop_sound_busy),
        .speed_front       (speed_front),
        .goal_front        (goal_front),
        .speed_rear        (speed_rear),
        .goal_rear         (goal_rear),
        .step_time         (step_time),
        .fast_time         (fast_time),
        .drive_power       (drive_power),
        .engine_mode       (engine_mode),
        .travel_direction  (travel_direction),
        .lamp_pattern      (lamp_pattern),
        .start_sound_pulse (start_sound_pulse),
        .stop_sound_pulse  (stop_sound_pulse),
        .run_sound_pulse   (run_sound_pulse)
    );

endmodule

// ----- rtl/core/detc_cfg.sv -----
// Configuration register file: gain, minimum drive, hold drive, ramp rate.
// Depends on detc_pkg.
module detc_cfg
    import detc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  cfg_index_t cfg_index,
    input  cfg_data_t  cfg_data,
    output cfg_t       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ERROR_GAIN: cfg_next.error_gain = cfg_data[GAIN_WIDTH-1:0];
                CFG_MIN_DRIVE:  cfg_next.min_drive  = cfg_data[DRIVE_WIDTH-1:0];
                CFG_HOLD_DRIVE: cfg_next.hold_drive = cfg_data[DRIVE_WIDTH-1:0];
                CFG_RAMP_RATE:  cfg_next.ramp_rate  = cfg_data[DRIVE_WIDTH-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.error_gain <= ERROR_GAIN_RESET;
            cfg_reg.min_drive  <= MIN_DRIVE_RESET;
            cfg_reg.hold_drive <= HOLD_DRIVE_RESET;
            cfg_reg.ramp_rate  <= RAMP_RATE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/core/detc_ctrl.sv -----
// Sequencer for the throttle datapath: accepts an item, steps the datapath
// through its phases and owns the result valid flag. Depends on detc_pkg.
module detc_ctrl
    import detc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output logic    out_valid,
    input  logic    out_stall,
    output dp_cmd_t cmd
);

    seq_state_t state_reg;
    seq_state_t state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || !out_stall;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE:   if (in_valid) state_next = SEQ_EVAL;
            SEQ_EVAL:   state_next = SEQ_SCALE;
            SEQ_SCALE:  state_next = SEQ_PICK;
            SEQ_PICK:   state_next = SEQ_RAMP;
            SEQ_RAMP:   state_next = SEQ_COMMIT;
            SEQ_COMMIT: if (out_free) state_next = SEQ_IDLE;
            default:    state_next = SEQ_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            SEQ_EVAL:   cmd.eval   = 1'b1;
            SEQ_SCALE:  cmd.scale  = 1'b1;
            SEQ_PICK:   cmd.pick   = 1'b1;
            SEQ_RAMP:   cmd.ramp   = 1'b1;
            SEQ_COMMIT: cmd.commit = out_free;
            default:    cmd        = '0;
        endcase
    end

    // Set on commit, drop once the result item is taken
    always_comb
    begin
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_free)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SEQ_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- rtl/core/detc_dp.sv -----
// Throttle datapath: direction latch, engine mode machine, target power law,
// divide-by-seven, slew step and result register. Depends on detc_pkg.
module detc_dp
    import detc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    cmd,
    input  cfg_t       cfg,
    input  logic [1:0] active_cab,
    input  logic [2:0] buttons_front,
    input  logic [2:0] buttons_rear,
    input  logic       start_sound_busy,
    input  logic       stop_sound_busy,
    input  speed_t     speed_front,
    input  speed_t     goal_front,
    input  speed_t     speed_rear,
    input  speed_t     goal_rear,
    input  dtime_t     step_time,
    input  logic       fast_time,
    output power_t     drive_power,
    output logic [1:0] engine_mode,
    output logic [1:0] travel_direction,
    output lamp_t      lamp_pattern,
    output logic       start_sound_pulse,
    output logic       stop_sound_pulse,
    output logic       run_sound_pulse
);

    function automatic pmag_t q14_to_pmag(input drive_t v);
        q14_t wide;
        wide = (q14_t'(v) << Q14_SHL) >> Q14_SHR;
        if (wide > q14_t'(PWR_ONE))
            return PWR_ONE;
        else
            return pmag_t'(wide);
    endfunction

    // Engine state
    dir_t   dir_reg,   dir_next;
    mode_t  mode_reg,  mode_next;
    power_t power_reg, power_next;

    // Item work registers
    act_t   actual_reg;
    speed_t goal_reg;
    dtime_t dt_reg;
    logic   fast_reg;
    logic   start_p_reg, stop_p_reg, run_p_reg;
    logic   zero_goal_reg, hold_sel_reg, opp_reg;
    pmag_t  tgt_base_reg;
    div7_prd_t div_prod_reg;
    pmag_t  tgt_reg, absdiff_reg, step_lim_reg;
    logic   dec_reg;
    mag_t   mag_reg;

    // Result registers
    power_t drive_power_reg;
    mode_t  mode_out_reg;
    dir_t   dir_out_reg;
    lamp_t  lamp_reg;
    logic   start_out_reg, stop_out_reg, run_out_reg;

    // Load phase
    act_t   act_sel;
    speed_t goal_sel;
    logic   start_p, stop_p, run_p;

    always_comb
    begin
        dir_next = dir_reg;
        act_sel  = '0;
        goal_sel = '0;
        if (active_cab == CAB_FRONT)
        begin
            if (buttons_front[BTN_NEUT])
                dir_next = DIR_NEUT;
            else if (buttons_front[BTN_FWD])
                dir_next = DIR_FWD;
            else if (buttons_front[BTN_REV])
                dir_next = DIR_REV;
            act_sel  = act_t'(speed_front);
            goal_sel = goal_front;
        end
        else if (active_cab == CAB_REAR)
        begin
            // aft cab sees the train the other way round
            if (buttons_rear[BTN_NEUT])
                dir_next = DIR_NEUT;
            else if (buttons_rear[BTN_FWD])
                dir_next = DIR_REV;
            else if (buttons_rear[BTN_REV])
                dir_next = DIR_FWD;
            act_sel  = -act_t'(speed_rear);
            goal_sel = goal_rear;
        end
    end

    always_comb
    begin
        mode_next = mode_reg;
        start_p   = 1'b0;
        stop_p    = 1'b0;
        run_p     = 1'b0;
        if (dir_next == DIR_FWD || dir_next == DIR_REV)
        begin
            unique case (mode_reg)
                MODE_OFF, MODE_STOP:
                begin
                    mode_next = MODE_START;
                    start_p   = 1'b1;
                end
                MODE_START: if (!start_sound_busy) mode_next = MODE_ON;
                MODE_ON:    run_p = 1'b1;
            endcase
        end
        else
        begin
            unique case (mode_reg)
                MODE_ON, MODE_START:
                begin
                    mode_next = MODE_STOP;
                    stop_p    = 1'b1;
                end
                MODE_STOP: if (!stop_sound_busy) mode_next = MODE_OFF;
                MODE_OFF:  mode_next = MODE_OFF;
            endcase
        end
    end

    // Evaluate phase: speed error and base target
    pmag_t min_p, hold_p, ramp_p, p_w;
    err_t  err_w;
    aerr_t ae_w, agoal_w;
    esc_t  esc_w, e_w;
    pmag_t base_w;
    logic  opp_w;

    assign min_p  = q14_to_pmag(cfg.min_drive);
    assign hold_p = q14_to_pmag(cfg.hold_drive);
    assign ramp_p = q14_to_pmag(cfg.ramp_rate);
    assign p_w    = power_reg[POWER_WIDTH-1] ? pmag_t'(-power_reg) : pmag_t'(power_reg);

    always_comb
    begin
        if (dir_reg == DIR_FWD)
            err_w = err_t'(goal_reg) - err_t'(actual_reg);
        else
            err_w = -err_t'(goal_reg) - err_t'(actual_reg);
        ae_w    = err_w[SPEED_WIDTH+1] ? aerr_t'(-err_w) : aerr_t'(err_w);
        agoal_w = goal_reg[SPEED_WIDTH-1] ? aerr_t'(-act_t'(goal_reg)) : aerr_t'(goal_reg);
        esc_w   = ((esc_t'(ae_w[SPD_FRAC-1:0]) * esc_t'(cfg.error_gain)) << ERR_SHL) >> ERR_SHR;

        if (cfg.error_gain == '0)
            e_w = '0;
        else if (ae_w >= SPD_ONE)
            e_w = esc_t'(PWR_ONE);
        else
            e_w = esc_w;

        if (e_w < esc_t'(min_p))
            base_w = min_p;
        else if (e_w > esc_t'(PWR_ONE))
            base_w = PWR_ONE;
        else
            base_w = pmag_t'(e_w);

        // train already moving against the correction
        opp_w = (actual_reg > 0 && err_w < 0) || (actual_reg < 0 && err_w > 0);
    end

    // Pick phase: final target and bounded step
    pmag_t tgt_w, div_q, absdiff_w, step_lim_w;
    logic  dec_w;
    div7_num_t div_num;

    assign div_num = (div7_num_t'(PWR_ONE) - div7_num_t'(tgt_base_reg)) << 1;
    assign div_q   = pmag_t'(div_prod_reg >> DIV7_SHIFT);

    always_comb
    begin
        priority if (zero_goal_reg)
            tgt_w = '0;
        else if (hold_sel_reg)
            tgt_w = hold_p;
        else if (opp_reg)
            tgt_w = div_q;
        else
            tgt_w = tgt_base_reg;

        dec_w     = tgt_w < p_w;
        absdiff_w = dec_w ? p_w - tgt_w : tgt_w - p_w;

        if (zero_goal_reg)
            step_lim_w = ramp_p;
        else if (absdiff_w < ramp_p)
            step_lim_w = absdiff_w;
        else
            step_lim_w = ramp_p;
    end

    // Commit phase
    pmag_t new_p;
    lamp_t lamp_w;

    always_comb
    begin
        if (mag_reg > mag_t'(absdiff_reg))
            new_p = tgt_reg;
        else if (dec_reg)
            new_p = p_w - pmag_t'(mag_reg);
        else
            new_p = p_w + pmag_t'(mag_reg);

        if (mode_reg != MODE_ON)
            power_next = '0;
        else if (dir_reg == DIR_REV)
            power_next = -power_t'(new_p);
        else
            power_next = power_t'(new_p);

        unique case (dir_reg)
            DIR_NEUT: lamp_w = LAMP_NEUT;
            DIR_FWD:  lamp_w = LAMP_FWD;
            default:  lamp_w = LAMP_REV;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg   <= DIR_NEUT;
            mode_reg  <= MODE_OFF;
            power_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                dir_reg  <= dir_next;
                mode_reg <= mode_next;
            end
            if (cmd.commit)
                power_reg <= power_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            actual_reg  <= act_sel;
            goal_reg    <= goal_sel;
            dt_reg      <= step_time;
            fast_reg    <= fast_time;
            start_p_reg <= start_p;
            stop_p_reg  <= stop_p;
            run_p_reg   <= run_p;
        end
        if (cmd.eval)
        begin
            zero_goal_reg <= agoal_w < TOL_GOAL;
            hold_sel_reg  <= (ae_w <= TOL_DEAD) || (ae_w < TOL_GOAL && fast_reg);
            opp_reg       <= opp_w;
            tgt_base_reg  <= base_w;
        end
        if (cmd.scale)
            div_prod_reg <= div7_prd_t'(div_num) * div7_prd_t'(DIV7_MUL);
        if (cmd.pick)
        begin
            tgt_reg      <= tgt_w;
            dec_reg      <= dec_w;
            absdiff_reg  <= absdiff_w;
            step_lim_reg <= step_lim_w;
        end
        if (cmd.ramp)
            mag_reg <= mag_t'((mprod_t'(step_lim_reg) * mprod_t'(dt_reg)) >> TIME_FRAC);
        if (cmd.commit)
        begin
            drive_power_reg <= power_next;
            mode_out_reg    <= mode_reg;
            dir_out_reg     <= dir_reg;
            lamp_reg        <= lamp_w;
            start_out_reg   <= start_p_reg;
            stop_out_reg    <= stop_p_reg;
            run_out_reg     <= run_p_reg;
        end
    end

    assign drive_power       = drive_power_reg;
    assign engine_mode       = mode_out_reg;
    assign travel_direction  = dir_out_reg;
    assign lamp_pattern      = lamp_reg;
    assign start_sound_pulse = start_out_reg;
    assign stop_sound_pulse  = stop_out_reg;
    assign run_sound_pulse   = run_out_reg;

endmodule

// ----- rtl/core/detc_checker.sv -----
// Port-level checks for the drive engine throttle controller, bound to the top.
// Depends on detc_pkg and drive_engine_throttle_controller_unit.
module detc_checker
    import detc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input power_t     drive_power,
    input logic [1:0] engine_mode,
    input logic [1:0] travel_direction,
    input lamp_t      lamp_pattern,
    input logic       start_sound_pulse,
    input logic       stop_sound_pulse,
    input logic       run_sound_pulse
);

    // One item at a time: stall right after an accepted item
    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after accepted item");

    // Held result item keeps its power, mode and direction
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(drive_power)
            && $stable(engine_mode) && $stable(travel_direction)))
        else $error("stalled result item changed");

    // Lamps follow direction
    a_lamps: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((travel_direction == DIR_NEUT && lamp_pattern == LAMP_NEUT)
            || (travel_direction == DIR_FWD && lamp_pattern == LAMP_FWD)
            || (travel_direction == DIR_REV && lamp_pattern == LAMP_REV)))
        else $error("lamp pattern does not match direction");

    // No power unless the engine runs
    a_power_off: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && engine_mode != MODE_ON) |-> (drive_power == '0))
        else $error("power while engine not on");

    // Sound pulses agree with the mode they announce
    a_pulses: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((!start_sound_pulse || engine_mode == MODE_START)
            && (!stop_sound_pulse || engine_mode == MODE_STOP)
            && (!run_sound_pulse || engine_mode == MODE_ON)))
        else $error("sound pulse inconsistent with engine mode");

endmodule

bind drive_engine_throttle_controller_unit detc_checker u_detc_checker (.*);
